>>> design/wsrc_pkg.sv
`default_nettype none
package wsrc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned LenW   = 33;
  localparam int unsigned SliceW = 31;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned ValW   = 64;
  localparam int unsigned CntW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgSliceLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgResPerUnit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCapPerUnit  = 2'd2;

  typedef struct packed {
    logic               net_start;
    logic signed [31:0] start_node;
    logic signed [31:0] end_node;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } seg_t;

  typedef struct packed {
    logic signed [31:0] from_id;
    logic signed [31:0] to_id;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [63:0]        resistance;
    logic [63:0]        half_cap;
    logic               last_piece;
    logic               overflow;
  } piece_t;

  // Classified segment passed from the front to the back.
  typedef struct packed {
    logic               net_start;
    logic               ovf;
    logic               x_major;
    logic               x_up;
    logic               y_up;
    logic [CntW-1:0]    n;
    logic [LenW-1:0]    maj;
    logic [LenW-1:0]    rest;
    logic signed [31:0] start_node;
    logic signed [31:0] end_node;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } job_t;

  typedef enum logic [1:0] {
    FeIdle,
    FeDiv,
    FePush
  } fe_state_e;

  typedef enum logic [2:0] {
    BeIdle,
    BeMulA,
    BeMulB,
    BeEmit
  } be_state_e;

endpackage
`default_nettype wire

>>> design/wsrc_if.sv
`default_nettype none
interface wsrc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/wsrc_front.sv
`default_nettype none
module wsrc_front #(
  parameter int unsigned MaxSlices = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire [wsrc_pkg::SliceW-1:0]  slice_len_i,
  wsrc_if.sink                        seg_in,
  output logic                        job_valid_o,
  output wsrc_pkg::job_t              job_o,
  input  wire                         job_ready_i
);
  import wsrc_pkg::*;

  fe_state_e state_q, state_d;
  seg_t seg_q;
  logic [LenW-1:0] dx_q, dy_q, len_q, rem_q, quo_q, s_q;
  logic [5:0] bit_q;
  logic [LenW-1:0] dx_c, dy_c, trial;
  logic [LenW-1:0] quo_c, rem_c;
  logic [LenW:0] nfull;

  assign dx_c = (seg_in.data.end_x > seg_in.data.start_x)
              ? LenW'({seg_in.data.end_x[31], seg_in.data.end_x}
                      - {seg_in.data.start_x[31], seg_in.data.start_x})
              : LenW'({seg_in.data.start_x[31], seg_in.data.start_x}
                      - {seg_in.data.end_x[31], seg_in.data.end_x});
  assign dy_c = (seg_in.data.end_y > seg_in.data.start_y)
              ? LenW'({seg_in.data.end_y[31], seg_in.data.end_y}
                      - {seg_in.data.start_y[31], seg_in.data.start_y})
              : LenW'({seg_in.data.start_y[31], seg_in.data.start_y}
                      - {seg_in.data.end_y[31], seg_in.data.end_y});

  // One quotient bit per cycle, restoring division.
  always_comb begin
    logic [LenW:0] sh;
    sh = {rem_q, len_q[LenW-1]};
    trial = LenW'(sh - {1'b0, s_q});
    if (sh >= {1'b0, s_q}) begin
      rem_c = trial;
      quo_c = {quo_q[LenW-2:0], 1'b1};
    end else begin
      rem_c = sh[LenW-1:0];
      quo_c = {quo_q[LenW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FeIdle: if (seg_in.valid) state_d = FeDiv;
      FeDiv:  if (bit_q == 6'd1) state_d = FePush;
      FePush: if (job_ready_i) state_d = FeIdle;
      default: state_d = FeIdle;
    endcase
  end

  always_comb begin
    seg_in.ready = (state_q == FeIdle);
    job_valid_o  = (state_q == FePush);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FeIdle) bit_q <= 6'(LenW);
      else if (state_q == FeDiv) bit_q <= bit_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FeIdle && seg_in.valid) begin
      seg_q <= seg_in.data;
      dx_q  <= dx_c;
      dy_q  <= dy_c;
      len_q <= dx_c + dy_c;
      rem_q <= '0;
      quo_q <= '0;
      s_q   <= (slice_len_i == '0) ? LenW'(1) : LenW'(slice_len_i);
    end else if (state_q == FeDiv) begin
      rem_q <= rem_c;
      quo_q <= quo_c;
      len_q <= {len_q[LenW-2:0], len_q[LenW-1]};
    end
  end

  // After LenW rotations len_q holds the length again.
  always_comb begin
    logic short_w;
    nfull = {1'b0, quo_q} + ((rem_q != '0) ? (LenW+1)'(1) : '0);
    short_w = (len_q <= s_q);
    job_o.net_start  = seg_q.net_start;
    job_o.ovf        = !short_w && (nfull > (LenW+1)'(MaxSlices));
    job_o.n          = short_w ? CntW'(1) : CntW'(nfull);
    job_o.x_major    = dx_q > dy_q;
    job_o.x_up       = seg_q.end_x > seg_q.start_x;
    job_o.y_up       = seg_q.end_y > seg_q.start_y;
    job_o.maj        = (dx_q > dy_q) ? dx_q : dy_q;
    job_o.rest       = short_w ? len_q
                     : ((rem_q != '0) ? rem_q : s_q);
    job_o.start_node = seg_q.start_node;
    job_o.end_node   = seg_q.end_node;
    job_o.start_x    = seg_q.start_x;
    job_o.start_y    = seg_q.start_y;
    job_o.end_x      = seg_q.end_x;
    job_o.end_y      = seg_q.end_y;
  end

endmodule
`default_nettype wire

>>> design/wsrc_queue.sv
`default_nettype none
module wsrc_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wsrc_pkg::job_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output wsrc_pkg::job_t data_o,
  input  wire            pop_i
);
  import wsrc_pkg::*;

  job_t mem_q [2];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

>>> design/wsrc_back.sv
`default_nettype none
module wsrc_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [wsrc_pkg::SliceW-1:0] slice_len_i,
  input  wire [wsrc_pkg::CoefW-1:0]  res_i,
  input  wire [wsrc_pkg::CoefW-1:0]  cap_i,
  input  wire                        job_valid_i,
  input  wsrc_pkg::job_t             job_i,
  output logic                       job_pop_o,
  wsrc_if.source                     rec_out
);
  import wsrc_pkg::*;

  be_state_e state_q, state_d;
  job_t job_q;
  logic [31:0] ctr_q;
  logic [CntW-1:0] k_q;
  logic [LenW-1:0] d_q, s_q;
  logic signed [31:0] prev_q;
  logic [ValW-1:0] rf_q, hf_q, rr_q, hr_q;
  logic [LenW-1:0] ml_len;
  logic [ValW:0] mr_p, mc_p;
  logic [ValW-1:0] mr_v, mc_v;
  logic [ValW-1:0] hsum;
  logic sel_rest_q;
  piece_t rec_q;
  logic [LenW-1:0] mj, mn, ox, oy;
  logic last_c;
  logic [31:0] ctr_dec;

  // Two 32x33 multipliers serve the full and the last piece in turn; the
  // capacitance uses half the length and adds half a unit for an odd length.
  assign ml_len = sel_rest_q ? job_q.rest : s_q;
  assign mr_p   = (ValW+1)'(res_i) * (ValW+1)'(ml_len);
  assign mc_p   = (ValW+1)'(cap_i) * (ValW+1)'(ml_len >> 1);
  assign mr_v   = mr_p[ValW] ? '1 : mr_p[ValW-1:0];
  always_comb begin
    logic [ValW:0] t;
    t = {1'b0, (mc_p[ValW] ? {ValW{1'b1}} : mc_p[ValW-1:0])}
      + (ml_len[0] ? (ValW+1)'(cap_i >> 1) : '0);
    hsum = t[ValW] ? '1 : t[ValW-1:0];
  end
  assign mc_v = hsum;

  assign last_c  = (k_q == job_q.n);
  assign ctr_dec = ctr_q - 32'd1;

  always_comb begin
    if (d_q <= job_q.maj) begin
      mj = d_q;
      mn = '0;
    end else begin
      mj = job_q.maj;
      mn = d_q - job_q.maj;
    end
    ox = job_q.x_major ? mj : mn;
    oy = job_q.x_major ? mn : mj;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BeIdle: if (job_valid_i) state_d = BeMulA;
      BeMulA: state_d = BeMulB;
      BeMulB: state_d = BeEmit;
      BeEmit: if (!rec_out.valid || rec_out.ready) begin
        if (last_c || job_q.ovf) state_d = BeIdle;
      end
      default: state_d = BeIdle;
    endcase
  end

  always_comb begin
    job_pop_o = (state_q == BeIdle) && job_valid_i;
  end

  assign rec_out.data = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BeIdle;
      ctr_q         <= '0;
      rec_out.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BeIdle && job_valid_i && job_i.net_start) ctr_q <= '0;
      if (state_q == BeEmit && (!rec_out.valid || rec_out.ready)) begin
        rec_out.valid <= 1'b1;
        if (!job_q.ovf && !last_c) ctr_q <= ctr_dec;
      end else if (rec_out.valid && rec_out.ready) begin
        rec_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BeIdle: begin
        job_q      <= job_i;
        s_q        <= (slice_len_i == '0) ? LenW'(1) : LenW'(slice_len_i);
        sel_rest_q <= 1'b0;
        k_q        <= CntW'(1);
      end
      BeMulA: begin
        rf_q       <= mr_v;
        hf_q       <= mc_v;
        sel_rest_q <= 1'b1;
        d_q        <= s_q;
        prev_q     <= job_q.start_node;
      end
      BeMulB: begin
        rr_q <= mr_v;
        hr_q <= mc_v;
      end
      BeEmit: if (!rec_out.valid || rec_out.ready) begin
        if (job_q.ovf) begin
          rec_q <= '{from_id: job_q.start_node, to_id: job_q.end_node,
                     point_x: job_q.end_x, point_y: job_q.end_y,
                     resistance: '0, half_cap: '0,
                     last_piece: 1'b1, overflow: 1'b1};
        end else if (last_c) begin
          rec_q <= '{from_id: prev_q, to_id: job_q.end_node,
                     point_x: job_q.end_x, point_y: job_q.end_y,
                     resistance: rr_q, half_cap: hr_q,
                     last_piece: 1'b1, overflow: 1'b0};
        end else begin
          rec_q <= '{from_id: prev_q, to_id: ctr_dec,
                     point_x: job_q.x_up ? job_q.start_x + ox[31:0]
                                         : job_q.start_x - ox[31:0],
                     point_y: job_q.y_up ? job_q.start_y + oy[31:0]
                                         : job_q.start_y - oy[31:0],
                     resistance: rf_q, half_cap: hf_q,
                     last_piece: 1'b0, overflow: 1'b0};
          prev_q <= ctr_dec;
          k_q    <= k_q + CntW'(1);
          d_q    <= d_q + s_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/wire_segment_rc_slicer_unit.sv
// Channel  Dir  Payload   Meaning
// seg      in   seg_t     one wire segment per beat
// rec      out  piece_t   one resistor record per beat
// The front takes a beat while idle, divides the length by the slice length
// one quotient bit per cycle, then hands the segment to a two-entry queue,
// waiting while it is full. The back takes a job while idle, multiplies in
// BeMulA and BeMulB, then emits its records, holding each while the receiver
// stalls. Reset clears all control state and restores the registers. Either
// side stalls on its own; the queue decouples them.
`default_nettype none
module wire_segment_rc_slicer_unit #(
  parameter int unsigned MAX_SLICES = 64
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [wsrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [wsrc_pkg::CfgDataW-1:0]  cfg_data_i,
  wsrc_if.sink                          seg,
  wsrc_if.source                        rec
);
  import wsrc_pkg::*;

  logic [SliceW-1:0] slice_q;
  logic [CoefW-1:0] res_q, cap_q;
  logic fe_valid, q_full, q_valid, q_pop;
  job_t fe_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '1;
      res_q   <= '0;
      cap_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSliceLength: slice_q <= cfg_data_i[SliceW-1:0];
        CfgResPerUnit:  res_q   <= cfg_data_i;
        CfgCapPerUnit:  cap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wsrc_front #(.MaxSlices(MAX_SLICES)) u_front (
    .clk_i, .rst_ni, .slice_len_i(slice_q), .seg_in(seg),
    .job_valid_o(fe_valid), .job_o(fe_job), .job_ready_i(!q_full)
  );

  wsrc_queue u_queue (
    .clk_i, .rst_ni, .push_i(fe_valid && !q_full), .data_i(fe_job),
    .full_o(q_full), .valid_o(q_valid), .data_o(q_job), .pop_i(q_pop)
  );

  wsrc_back u_back (
    .clk_i, .rst_ni, .slice_len_i(slice_q), .res_i(res_q), .cap_i(cap_q),
    .job_valid_i(q_valid), .job_i(q_job), .job_pop_o(q_pop), .rec_out(rec)
  );

endmodule
`default_nettype wire

>>> tb/wsrc_checker.sv
`default_nettype none
module wsrc_checker #(
  parameter int unsigned MAX_SLICES = 64
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [wsrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [wsrc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                           seg_valid_i,
  input  wire                           seg_ready_i,
  input  wsrc_pkg::seg_t                seg_i,
  input  wire                           rec_valid_i,
  input  wire                           rec_ready_i,
  input  wsrc_pkg::piece_t              rec_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  import wsrc_pkg::*;

  localparam logic [63:0] Sat = 64'hFFFF_FFFF_FFFF_FFFF;

  logic [30:0] slice_len;
  logic [31:0] res_coef;
  logic [31:0] cap_coef;
  logic [31:0] node_ctr;
  piece_t      expected_pieces[$];

  function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? Sat : p[63:0];
  endfunction

  function automatic logic [63:0] half_cap_of(logic [63:0] len);
    logic [63:0] p;
    logic [63:0] h;
    p = sat_mul({32'd0, cap_coef}, len >> 1);
    h = {33'd0, cap_coef[31:1]};
    if (len[0]) begin
      p = (p > Sat - h) ? Sat : p + h;
    end
    return p;
  endfunction

  task automatic slice_segment(input seg_t s);
    longint      sx, sy, ex, ey, px, py;
    logic [63:0] step, dx, dy, len, n, d, maj, mj, mn, ox, oy, rest;
    logic [31:0] prev;
    bit          xmaj;
    piece_t      pc;
    sx = longint'(s.start_x);
    sy = longint'(s.start_y);
    ex = longint'(s.end_x);
    ey = longint'(s.end_y);
    step = (slice_len == 0) ? 64'd1 : {33'd0, slice_len};
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    len = dx + dy;
    xmaj = dx > dy;
    if (s.net_start) node_ctr = '0;
    pc = '0;
    pc.from_id = s.start_node;
    pc.to_id = s.end_node;
    pc.point_x = s.end_x;
    pc.point_y = s.end_y;
    pc.last_piece = 1'b1;
    if (len <= step) begin
      pc.resistance = sat_mul({32'd0, res_coef}, len);
      pc.half_cap = half_cap_of(len);
      expected_pieces = {expected_pieces, pc};
      return;
    end
    n = len / step + ((len % step) != 0);
    if (n > MAX_SLICES) begin
      pc.overflow = 1'b1;
      expected_pieces = {expected_pieces, pc};
      return;
    end
    prev = s.start_node;
    maj = xmaj ? dx : dy;
    for (logic [63:0] k = 1; k < n; k++) begin
      d = k * step;
      if (d <= maj) begin
        mj = d;
        mn = 0;
      end else begin
        mj = maj;
        mn = d - maj;
      end
      ox = xmaj ? mj : mn;
      oy = xmaj ? mn : mj;
      px = (ex > sx) ? sx + longint'(ox) : sx - longint'(ox);
      py = (ey > sy) ? sy + longint'(oy) : sy - longint'(oy);
      node_ctr = node_ctr - 1;
      pc = '0;
      pc.from_id = prev;
      pc.to_id = node_ctr;
      pc.point_x = px[31:0];
      pc.point_y = py[31:0];
      pc.resistance = sat_mul({32'd0, res_coef}, step);
      pc.half_cap = half_cap_of(step);
      expected_pieces = {expected_pieces, pc};
      prev = node_ctr;
    end
    rest = len - (n - 1) * step;
    pc = '0;
    pc.from_id = prev;
    pc.to_id = s.end_node;
    pc.point_x = s.end_x;
    pc.point_y = s.end_y;
    pc.resistance = sat_mul({32'd0, res_coef}, rest);
    pc.half_cap = half_cap_of(rest);
    pc.last_piece = 1'b1;
    expected_pieces = {expected_pieces, pc};
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    piece_t want;
    if (!rst_ni) begin
      slice_len <= 31'h7FFF_FFFF;
      res_coef  <= '0;
      cap_coef  <= '0;
      node_ctr  = '0;
    end else begin
      if (seg_valid_i && seg_ready_i) slice_segment(seg_i);
      if (rec_valid_i && rec_ready_i) begin
        if (expected_pieces.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %p", $time, rec_i);
          fail_cnt_o++;
        end else begin
          want = expected_pieces.pop_front();
          check_field("from_id", 64'(want.from_id), 64'(rec_i.from_id));
          check_field("to_id", 64'(want.to_id), 64'(rec_i.to_id));
          check_field("point_x", 64'(want.point_x), 64'(rec_i.point_x));
          check_field("point_y", 64'(want.point_y), 64'(rec_i.point_y));
          check_field("resistance", want.resistance, rec_i.resistance);
          check_field("half_cap", want.half_cap, rec_i.half_cap);
          check_field("last_piece", 64'(want.last_piece), 64'(rec_i.last_piece));
          check_field("overflow", 64'(want.overflow), 64'(rec_i.overflow));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSliceLength: slice_len <= cfg_data_i[30:0];
          CfgResPerUnit: res_coef <= cfg_data_i;
          CfgCapPerUnit: cap_coef <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_pieces.size();
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_wire_segment_rc_slicer_unit.sv
`default_nettype none
module tb_wire_segment_rc_slicer_unit;
  import wsrc_pkg::*;

  localparam int Limit = 3000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgSliceLength;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  fail_cnt;
  int                  pending;
  int                  mode = 0;
  int                  cycles = 0;
  int                  hold_left = 0;
  bit                  hold_req = 0;
  bit                  hold_done = 0;

  wsrc_if #(.T(seg_t))   seg_ch ();
  wsrc_if #(.T(piece_t)) rec_ch ();

  always #4 clk_i = ~clk_i;

  wire_segment_rc_slicer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .seg(seg_ch), .rec(rec_ch)
  );

  wsrc_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .seg_valid_i(seg_ch.valid), .seg_ready_i(seg_ch.ready), .seg_i(seg_ch.data),
    .rec_valid_i(rec_ch.valid), .rec_ready_i(rec_ch.ready), .rec_i(rec_ch.data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side: random stalls per mode, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      rec_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rec_ch.ready <= 1'b0;
    end else if (mode == 2) begin
      rec_ch.ready <= $urandom_range(0, 99) >= 60;
    end else if (mode == 3) begin
      rec_ch.ready <= $urandom_range(0, 99) >= 8;
    end else begin
      rec_ch.ready <= 1'b1;
    end
  end

  function automatic seg_t place_seg(longint dx, longint dy, bit ns);
    seg_t   s;
    longint lo;
    s.net_start = ns;
    s.start_node = $urandom;
    s.end_node = $urandom;
    lo = -64'sd2147483648 + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - dx)));
    if ($urandom_range(0, 1)) begin
      s.start_x = lo[31:0];
      s.end_x = 32'(lo + dx);
    end else begin
      s.end_x = lo[31:0];
      s.start_x = 32'(lo + dx);
    end
    lo = -64'sd2147483648 + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - dy)));
    if ($urandom_range(0, 1)) begin
      s.start_y = lo[31:0];
      s.end_y = 32'(lo + dy);
    end else begin
      s.end_y = lo[31:0];
      s.start_y = 32'(lo + dy);
    end
    return s;
  endfunction

  function automatic seg_t random_seg(longint step);
    longint       total, dmin, dmax, dx;
    int           pick;
    seg_t         s;
    logic [223:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s = raw[$bits(seg_t)-1:0];
      return s;
    end
    total = longint'($urandom_range(1, 68) - 1) * step + longint'($urandom_range(1, 32'(step)));
    if (pick < 20) total = longint'($urandom_range(1, 66)) * step;
    if (pick < 23) total = 0;
    if (total > 64'h1_FFFF_FFFE) total = 64'h1_FFFF_FFFE;
    dmin = (total > 64'hFFFF_FFFF) ? total - 64'hFFFF_FFFF : 0;
    dmax = (total > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : total;
    dx = dmin + longint'($urandom_range(0, 32'(dmax - dmin)));
    return place_seg(dx, total - dx, $urandom_range(0, 3) == 0);
  endfunction

  task automatic send_seg(input seg_t s);
    int idle_pct;
    idle_pct = (mode == 1) ? 60 : (mode == 3) ? 8 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      seg_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.data <= s;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    seg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [30:0] len, input logic [31:0] res,
                           input logic [31:0] cap);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSliceLength;
    cfg_data_i <= {1'b0, len};
    @(posedge clk_i);
    cfg_idx_i <= CfgResPerUnit;
    cfg_data_i <= res;
    @(posedge clk_i);
    cfg_idx_i <= CfgCapPerUnit;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input longint step);
    for (int i = 0; i < count; i++) begin
      if (i == 5 && mode == 2) hold_req = 1'b1;
      if (i == 20 && mode == 2) drain();
      send_seg(random_seg(step));
    end
  endtask

  initial begin
    seg_t s;
    seg_ch.valid <= 1'b0;
    seg_ch.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mode = 0;
    run_random(20, 64'h7FFF_FFFF);
    drain();

    write_cfg(31'd100, 32'h0001_8000, 32'h0000_4001);
    send_seg(place_seg(0, 0, 1'b1));
    send_seg(place_seg(100, 0, 1'b0));
    send_seg(place_seg(101, 0, 1'b0));
    send_seg(place_seg(0, 200, 1'b0));
    send_seg(place_seg(150, 150, 1'b0));
    send_seg(place_seg(250, 30, 1'b1));
    send_seg(place_seg(30, 250, 1'b0));
    send_seg(place_seg(6400, 0, 1'b0));
    send_seg(place_seg(6401, 0, 1'b0));
    send_seg(place_seg(3200, 3199, 1'b1));
    send_seg(place_seg(64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0));
    s = place_seg(33, 77, 1'b0);
    s.start_node = 32'sh8000_0000;
    s.end_node = 32'sh7FFF_FFFF;
    send_seg(s);
    drain();

    write_cfg(31'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    mode = 1;
    run_random(40, 1);
    drain();

    write_cfg(31'd1000, $urandom, $urandom);
    mode = 2;
    run_random(40, 1000);
    drain();

    write_cfg(31'h7FFF_FFFF, $urandom, 32'd0);
    mode = 3;
    run_random(40, 64'h7FFF_FFFF);
    drain();

    write_cfg(31'd0, $urandom_range(0, 255), $urandom);
    mode = 0;
    run_random(40, 1);
    drain();

    write_cfg(31'($urandom_range(2, 100000)), $urandom, $urandom);
    mode = 3;
    run_random(40, 100000);
    drain();

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
